// ===== hdl/low_memory_threshold_notifier_assert.svh =====
// Assertion helpers used by the notifier datapath (lmtn_dp).
`ifndef LOW_MEMORY_THRESHOLD_NOTIFIER_ASSERT_SVH
`define LOW_MEMORY_THRESHOLD_NOTIFIER_ASSERT_SVH

// Check that cons holds in every cycle in which ante holds.
`define LMTN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cond holds in every cycle out of reset.
`define LMTN_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== hdl/lmtn_pkg.sv =====
package lmtn_pkg;

  localparam int DEF_MAX_THRESHOLDS   = 16;
  localparam int DEF_PAGE_COUNT_WIDTH = 32;

  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int REQ_W        = 2;
  localparam int PCT_W        = 7;
  localparam int ID_W         = 10;
  localparam int LVL_OUT_W    = 5;
  localparam int CNT_OUT_W    = 5;
  localparam int PERCENT_BASE = 100;

  // 120 MiB of 4 KiB pages
  localparam logic [CFG_W-1:0] WS_RESET_PAGES = CFG_W'((120 * 1024 * 1024) >> 12);

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REG    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WORKING_SET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE = 2'd2;

  typedef struct packed {
    logic load;
    logic calc1;
    logic calc2;
    logic calc3;
    logic calc4;
    logic clear;
    logic set_full;
    logic idx_clamp;
    logic idx_inc;
    logic idx_dec;
    logic idx_cnt;
    logic lv_init;
    logic lvl_idx;
    logic lvl_inc;
    logic cnt_inc;
    logic rd_en;
    logic rd_prev;
    logic wr_shift;
    logic wr_new;
    logic emit_sig;
    logic emit_stat;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic cnt_zero;
    logic cnt_full;
    logic idx_neg;
    logic idx_zero;
    logic idx_ge_cnt;
    logic q_lt_use;
    logic q_lt_thr;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/low_memory_threshold_notifier.sv =====
// Low-memory threshold notifier. Each request carries page counts; the block forms
// usable = (free - reserve [+ swap_free]) + (file - swapcache) - working_set with every
// subtraction clamped at zero. For a sample or register request it then walks a
// descending table of thresholds and emits one crossing signal per threshold crossed
// since the previous request; every request ends with one status result (last = 1). A
// register request also inserts percent * total / 100, total being configuration
// register 1 (status = 1 when the table is full); a clear request empties the table.
// Steps: page arithmetic (C1 to C4), a start state for the walk, then a read and a
// compare state per table entry walked, since the table is a memory with one registered
// read port, and a status state. The divide by 100 is a reciprocal multiplication spread
// over the arithmetic steps, so the insert never waits for it. A register request then
// moves the entries below the new threshold down one by one (read, compare, shift write),
// writes the new entry and rescans the table, entry by entry, to set the level.
// One request is worked on at a time; stall stays high until its status result is in
// the output register, and a signal or the status result waits whenever that register
// is still full and stalled.
// Configuration writes take effect at once and must only arrive while idle.
module low_memory_threshold_notifier #(
  parameter int MAX_THRESHOLDS   = lmtn_pkg::DEF_MAX_THRESHOLDS,
  parameter int PAGE_COUNT_WIDTH = lmtn_pkg::DEF_PAGE_COUNT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lmtn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lmtn_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lmtn_pkg::REQ_W-1:0]            in_req_type,
  input  logic [PAGE_COUNT_WIDTH-1:0]           in_free_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]           in_reserve_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]           in_file_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]           in_swapcache_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]           in_swap_free_pages,
  input  logic [lmtn_pkg::PCT_W-1:0]            in_threshold_percent,
  input  logic [lmtn_pkg::ID_W-1:0]             in_event_id,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_result_kind,
  output logic [lmtn_pkg::ID_W-1:0]             out_signal_id,
  output logic [PAGE_COUNT_WIDTH-1:0]           out_crossed_threshold,
  output logic signed [lmtn_pkg::LVL_OUT_W-1:0] out_level_index,
  output logic [lmtn_pkg::CNT_OUT_W-1:0]        out_entry_count,
  output logic [PAGE_COUNT_WIDTH-1:0]           out_usable_count,
  output logic                                  out_status,
  output logic                                  out_last
);
  import lmtn_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t st;

  // sequencer: accept a request, step the arithmetic, walk, insert, report
  lmtn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: configuration, page arithmetic, divider, table memories, result register
  lmtn_dp #(
    .MAX_THRESHOLDS   (MAX_THRESHOLDS),
    .PAGE_COUNT_WIDTH (PAGE_COUNT_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_req_type           (in_req_type),
    .in_free_pages         (in_free_pages),
    .in_reserve_pages      (in_reserve_pages),
    .in_file_pages         (in_file_pages),
    .in_swapcache_pages    (in_swapcache_pages),
    .in_swap_free_pages    (in_swap_free_pages),
    .in_threshold_percent  (in_threshold_percent),
    .in_event_id           (in_event_id),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_kind       (out_result_kind),
    .out_signal_id         (out_signal_id),
    .out_crossed_threshold (out_crossed_threshold),
    .out_level_index       (out_level_index),
    .out_entry_count       (out_entry_count),
    .out_usable_count      (out_usable_count),
    .out_status            (out_status),
    .out_last              (out_last)
  );

endmodule

// ===== hdl/lmtn_ctrl.sv =====
module lmtn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lmtn_pkg::stat_t st,
  output lmtn_pkg::cmd_t  cmd
);
  import lmtn_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_C1      = 18'b000000000000000010,
    S_C2      = 18'b000000000000000100,
    S_C3      = 18'b000000000000001000,
    S_C4      = 18'b000000000000010000,
    S_WINIT   = 18'b000000000000100000,
    S_DN_RD   = 18'b000000000001000000,
    S_DN_CMP  = 18'b000000000010000000,
    S_UP_RD   = 18'b000000000100000000,
    S_UP_CMP  = 18'b000000001000000000,
    S_INS_WT  = 18'b000000010000000000,
    S_INS_RD  = 18'b000000100000000000,
    S_INS_CMP = 18'b000001000000000000,
    S_INS_WR  = 18'b000010000000000000,
    S_LV_RD   = 18'b000100000000000000,
    S_LV_CMP  = 18'b001000000000000000,
    S_STAT    = 18'b010000000000000000,
    S_SPARE   = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt, post_walk;

  assign in_stall = (state_r != S_IDLE);

  // after the walk: register requests go on to insert unless the table is full
  always_comb begin
    if (st.req == REQ_REG && !st.cnt_full) begin
      post_walk = S_INS_WT;
    end else begin
      post_walk = S_STAT;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        cmd.calc1 = 1'b1;
        state_nxt = S_C2;
      end
      S_C2: begin
        cmd.calc2 = 1'b1;
        state_nxt = S_C3;
      end
      S_C3: begin
        cmd.calc3 = 1'b1;
        state_nxt = S_C4;
      end
      S_C4: begin
        cmd.calc4 = 1'b1;
        if (st.req == REQ_SAMPLE || st.req == REQ_REG) begin
          state_nxt = S_WINIT;
        end else begin
          cmd.clear = (st.req == REQ_CLEAR);
          state_nxt = S_STAT;
        end
      end
      S_WINIT: begin
        if (st.cnt_zero) begin
          cmd.set_full = (st.req == REQ_REG) && st.cnt_full;
          state_nxt    = post_walk;
        end else begin
          cmd.idx_clamp = 1'b1;
          state_nxt     = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (st.idx_neg) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.q_lt_use) begin
          if (st.out_free) begin
            cmd.emit_sig = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_nxt    = S_DN_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (st.idx_ge_cnt) begin
          cmd.lvl_idx  = 1'b1;
          cmd.set_full = (st.req == REQ_REG) && st.cnt_full;
          state_nxt    = post_walk;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (!st.q_lt_use) begin
          if (st.out_free) begin
            cmd.emit_sig = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_nxt    = S_UP_RD;
          end
        end else begin
          cmd.lvl_idx  = 1'b1;
          cmd.set_full = (st.req == REQ_REG) && st.cnt_full;
          state_nxt    = post_walk;
        end
      end
      S_INS_WT: begin
        if (st.div_done) begin
          cmd.idx_cnt = 1'b1;
          state_nxt   = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (st.idx_zero) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (st.q_lt_thr) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          state_nxt    = S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.lv_init = 1'b1;
        state_nxt   = S_LV_RD;
      end
      S_LV_RD: begin
        if (st.idx_ge_cnt) begin
          state_nxt = S_STAT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_LV_CMP;
        end
      end
      S_LV_CMP: begin
        cmd.lvl_inc = !st.q_lt_use;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_LV_RD;
      end
      S_STAT: begin
        if (st.out_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lmtn_dp.sv =====
module lmtn_dp #(
  parameter int MAX_THRESHOLDS   = lmtn_pkg::DEF_MAX_THRESHOLDS,
  parameter int PAGE_COUNT_WIDTH = lmtn_pkg::DEF_PAGE_COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lmtn_pkg::cmd_t                    cmd,
  output lmtn_pkg::stat_t                   st,
  input  logic                              cfg_we,
  input  logic [lmtn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmtn_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [lmtn_pkg::REQ_W-1:0]        in_req_type,
  input  logic [PAGE_COUNT_WIDTH-1:0]       in_free_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]       in_reserve_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]       in_file_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]       in_swapcache_pages,
  input  logic [PAGE_COUNT_WIDTH-1:0]       in_swap_free_pages,
  input  logic [lmtn_pkg::PCT_W-1:0]        in_threshold_percent,
  input  logic [lmtn_pkg::ID_W-1:0]         in_event_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_result_kind,
  output logic [lmtn_pkg::ID_W-1:0]         out_signal_id,
  output logic [PAGE_COUNT_WIDTH-1:0]       out_crossed_threshold,
  output logic signed [lmtn_pkg::LVL_OUT_W-1:0] out_level_index,
  output logic [lmtn_pkg::CNT_OUT_W-1:0]    out_entry_count,
  output logic [PAGE_COUNT_WIDTH-1:0]       out_usable_count,
  output logic                              out_status,
  output logic                              out_last
);
  import lmtn_pkg::*;

  localparam int PW    = PAGE_COUNT_WIDTH;
  localparam int CW    = $clog2(MAX_THRESHOLDS + 1);
  localparam int IXW   = CW + 1;
  localparam int AW    = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
  localparam int PRODW = PCT_W + CFG_W;
  localparam int REMW  = $clog2(PERCENT_BASE);
  localparam int DW    = 2 * CFG_W;
  localparam int SMW   = PCT_W + REMW;
  localparam logic [63:0] MASK64 = {64{1'b1}} >> (64 - PW);
  localparam logic signed [IXW-1:0] ONE_S = IXW'(1);
  // total / 100 for a 32-bit total: multiply by ceil(2^37 / 100), keep the top bits
  localparam logic [CFG_W-1:0] RECIP_BIG   = 32'h51EB851F;
  localparam int               BIG_SHIFT   = 37;
  // small products below 2^14: multiply by ceil(2^20 / 100)
  localparam logic [SMW-1:0]   RECIP_SMALL = SMW'(10486);
  localparam int               SMALL_SHIFT = 20;

  function automatic logic [PW-1:0] sat_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PW] ? {PW{1'b1}} : s[PW-1:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] ws_r, total_r;
  logic             swen_r;
  logic [63:0]      ws64;
  logic [PW-1:0]    ws_pw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= WS_RESET_PAGES;
      total_r <= '0;
      swen_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORKING_SET: ws_r    <= cfg_wdata;
        CFG_TOTAL_PAGES: total_r <= cfg_wdata;
        CFG_SWAP_ENABLE: swen_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign ws64  = 64'(ws_r);
  assign ws_pw = ws64[PW-1:0];

  // request capture and usable-page arithmetic
  logic [REQ_W-1:0] req_r;
  logic [PW-1:0]    f_r, rv_r, fl_r, sc_r, sw_r;
  logic [PCT_W-1:0] pct_r;
  logic [ID_W-1:0]  id_r;
  logic             full_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      f_r   <= in_free_pages;
      rv_r  <= in_reserve_pages;
      fl_r  <= in_file_pages;
      sc_r  <= in_swapcache_pages;
      sw_r  <= in_swap_free_pages;
      pct_r <= in_threshold_percent;
      id_r  <= in_event_id;
    end else if (cmd.calc1) begin
      f_r  <= sat_sub(f_r, rv_r);
      fl_r <= sat_sub(fl_r, sc_r);
    end else if (cmd.calc2) begin
      if (swen_r) begin
        f_r <= sat_add(f_r, sw_r);
      end
    end else if (cmd.calc3) begin
      f_r <= sat_add(f_r, fl_r);
    end else if (cmd.calc4) begin
      f_r <= sat_sub(f_r, ws_pw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (cmd.load) begin
      full_r <= 1'b0;
    end else if (cmd.set_full) begin
      full_r <= 1'b1;
    end
  end

  // threshold = percent * total / 100 over the arithmetic steps calc1 to calc4:
  // split total = 100 * q + r, then percent * q + (percent * r) / 100
  logic [DW-1:0]    qbig;
  logic [CFG_W-1:0] q100_r, rem_full;
  logic [REMW-1:0]  rem_r;
  logic [PRODW-1:0] pq_r, quo_r;
  logic [SMW-1:0]   pr_r;
  logic [2*SMW-1:0] prm;
  logic             quo_ok_r;
  logic [63:0]      quo64;
  logic [PW-1:0]    thr_pw;

  assign qbig     = DW'(total_r) * DW'(RECIP_BIG);
  assign rem_full = total_r - q100_r * CFG_W'(PERCENT_BASE);
  assign prm      = (2*SMW)'(pr_r) * (2*SMW)'(RECIP_SMALL);

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      q100_r <= CFG_W'(qbig >> BIG_SHIFT);
    end else if (cmd.calc2) begin
      rem_r <= rem_full[REMW-1:0];
    end else if (cmd.calc3) begin
      pq_r <= PRODW'(pct_r) * PRODW'(q100_r);
      pr_r <= SMW'(pct_r) * SMW'(rem_r);
    end else if (cmd.calc4) begin
      quo_r <= pq_r + PRODW'(prm >> SMALL_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_ok_r <= 1'b0;
    end else if (cmd.load) begin
      quo_ok_r <= 1'b0;
    end else if (cmd.calc4) begin
      quo_ok_r <= 1'b1;
    end
  end

  assign quo64  = 64'(quo_r);
  assign thr_pw = (quo64 > MASK64) ? MASK64[PW-1:0] : quo64[PW-1:0];

  // table bookkeeping
  logic [CW-1:0]         cnt_r;
  logic signed [IXW-1:0] idx_r, lvl_r, cnt_s;

  assign cnt_s = $signed({1'b0, cnt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lvl_r <= '1;
    end else if (cmd.clear) begin
      cnt_r <= '0;
      lvl_r <= '1;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.lv_init) begin
        lvl_r <= '1;
      end else if (cmd.lvl_inc) begin
        lvl_r <= lvl_r + ONE_S;
      end else if (cmd.lvl_idx) begin
        lvl_r <= idx_r - ONE_S;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clamp) begin
      idx_r <= (lvl_r >= cnt_s) ? (cnt_s - ONE_S) : lvl_r;
    end else if (cmd.idx_cnt) begin
      idx_r <= cnt_s;
    end else if (cmd.lv_init) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + ONE_S;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - ONE_S;
    end
  end

  // threshold and listener memories, one write and one registered read port
  logic [PW-1:0]   thr_mem [MAX_THRESHOLDS];
  logic [ID_W-1:0] lis_mem [MAX_THRESHOLDS];
  logic [PW-1:0]   thr_q;
  logic [ID_W-1:0] lis_q;
  logic [IXW-1:0]  rd_idx;
  logic [AW-1:0]   rd_addr, wr_addr;

  assign rd_idx  = cmd.rd_prev ? (idx_r - ONE_S) : idx_r;
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      thr_mem[wr_addr] <= thr_q;
      lis_mem[wr_addr] <= lis_q;
    end else if (cmd.wr_new) begin
      thr_mem[wr_addr] <= thr_pw;
      lis_mem[wr_addr] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      thr_q <= thr_mem[rd_addr];
      lis_q <= lis_mem[rd_addr];
    end
  end

  // result register
  logic                  ov_r;
  logic                  kind_r, ostat_r, last_r;
  logic [ID_W-1:0]       sid_r;
  logic [PW-1:0]         cthr_r, use_r;
  logic [LVL_OUT_W-1:0]  olvl_r;
  logic [CNT_OUT_W-1:0]  ocnt_r;
  logic signed [31:0]    lvl32;
  logic [31:0]           cnt32;

  assign lvl32 = 32'(lvl_r);
  assign cnt32 = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_sig || cmd.emit_stat) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sig) begin
      kind_r  <= 1'b0;
      sid_r   <= lis_q;
      cthr_r  <= thr_q;
      olvl_r  <= '0;
      ocnt_r  <= '0;
      use_r   <= f_r;
      ostat_r <= 1'b0;
      last_r  <= 1'b0;
    end else if (cmd.emit_stat) begin
      kind_r  <= 1'b1;
      sid_r   <= '0;
      cthr_r  <= '0;
      olvl_r  <= lvl32[LVL_OUT_W-1:0];
      ocnt_r  <= cnt32[CNT_OUT_W-1:0];
      use_r   <= f_r;
      ostat_r <= full_r;
      last_r  <= 1'b1;
    end
  end

  assign out_valid             = ov_r;
  assign out_result_kind       = kind_r;
  assign out_signal_id         = sid_r;
  assign out_crossed_threshold = cthr_r;
  assign out_level_index       = $signed(olvl_r);
  assign out_entry_count       = ocnt_r;
  assign out_usable_count      = use_r;
  assign out_status            = ostat_r;
  assign out_last              = last_r;

  // status toward the controller
  always_comb begin
    st            = '0;
    st.req        = req_r;
    st.cnt_zero   = (cnt_r == '0);
    st.cnt_full   = (cnt_r == CW'(MAX_THRESHOLDS));
    st.idx_neg    = idx_r[IXW-1];
    st.idx_zero   = (idx_r == '0);
    st.idx_ge_cnt = (idx_r >= cnt_s);
    st.q_lt_use   = (thr_q < f_r);
    st.q_lt_thr   = (thr_q < thr_pw);
    st.div_done   = quo_ok_r;
    st.out_free   = !ov_r || !out_stall;
  end

`include "low_memory_threshold_notifier_assert.svh"

  `LMTN_ASSERT_IMP(a_emit_free, (cmd.emit_sig || cmd.emit_stat), (!ov_r || !out_stall), "result overwritten while stalled")
  `LMTN_ASSERT_ALW(a_cnt_bound, (cnt_r <= CW'(MAX_THRESHOLDS)), "table count beyond depth")
  `LMTN_ASSERT_IMP(a_wr_range, (cmd.wr_shift || cmd.wr_new), (!idx_r[IXW-1] && idx_r < $signed(IXW'(MAX_THRESHOLDS))), "table write outside depth")
  `LMTN_ASSERT_IMP(a_ins_room, cmd.wr_new, (cnt_r < CW'(MAX_THRESHOLDS) && quo_ok_r), "insert into full table or before divide done")

endmodule

// ===== test/low_memory_threshold_notifier_tb.sv =====
`timescale 1ns / 100ps

module low_memory_threshold_notifier_tb;
  import lmtn_pkg::*;

  localparam int NTHR = DEF_MAX_THRESHOLDS;
  localparam int PW   = DEF_PAGE_COUNT_WIDTH;
  localparam logic [PW-1:0] PAGE_MAX = '1;
  // Unused request code: the block must answer it with a bare status result.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [REQ_W-1:0] req_type;
    logic [PW-1:0]    free_cnt;
    logic [PW-1:0]    reserve_pages;
    logic [PW-1:0]    file_pages;
    logic [PW-1:0]    swapcache_pages;
    logic [PW-1:0]    swap_free_pages;
    logic [PCT_W-1:0] threshold_percent;
    logic [ID_W-1:0]  event_id;
  } mem_request_t;

  typedef struct {
    logic                 result_kind;
    logic [ID_W-1:0]      signal_id;
    logic [PW-1:0]        crossed_threshold;
    logic [LVL_OUT_W-1:0] level_index;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [PW-1:0]        usable_count;
    logic                 status;
    logic                 last;
  } notice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [PW-1:0] in_free_pages = '0;
  logic [PW-1:0] in_reserve_pages = '0;
  logic [PW-1:0] in_file_pages = '0;
  logic [PW-1:0] in_swapcache_pages = '0;
  logic [PW-1:0] in_swap_free_pages = '0;
  logic [PCT_W-1:0] in_threshold_percent = '0;
  logic [ID_W-1:0] in_event_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_result_kind;
  logic [ID_W-1:0] out_signal_id;
  logic [PW-1:0] out_crossed_threshold;
  logic signed [LVL_OUT_W-1:0] out_level_index;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic [PW-1:0] out_usable_count;
  logic out_status;
  logic out_last;

  low_memory_threshold_notifier DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_free_pages(in_free_pages),
    .in_reserve_pages(in_reserve_pages), .in_file_pages(in_file_pages),
    .in_swapcache_pages(in_swapcache_pages), .in_swap_free_pages(in_swap_free_pages),
    .in_threshold_percent(in_threshold_percent), .in_event_id(in_event_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_signal_id(out_signal_id),
    .out_crossed_threshold(out_crossed_threshold), .out_level_index(out_level_index),
    .out_entry_count(out_entry_count), .out_usable_count(out_usable_count),
    .out_status(out_status), .out_last(out_last)
  );

  // Shadow of the block: threshold table, listeners, count, level and registers.
  logic [PW-1:0]   shadow_thr [NTHR];
  logic [ID_W-1:0] shadow_id  [NTHR];
  int              shadow_count;
  int              shadow_level;
  logic [PW-1:0]   ws_pages;
  logic [PW-1:0]   total_cfg;
  logic            swap_on;

  notice_t pending_notices[$];

  int fail_count = 0;
  int requests_sent = 0;
  int notices_seen = 0;
  int crossings_seen = 0;
  int full_errors = 0;

  // Pressure knobs: sender idle chance per request, receiver stall chance per cycle (percent).
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_start = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stall, or a long hold-off counted here once requested.
  always @(posedge clk) begin
    if (hold_start > 0) begin
      hold_left = hold_start;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Checker: compare each accepted result with the oldest pending notice.
  always @(posedge clk) begin
    notice_t exp_n;
    if (rst_n && out_valid && !out_stall) begin
      notices_seen++;
      if (pending_notices.size() == 0) begin
        $error("unexpected result: kind %0d id %0d usable %0d", out_result_kind,
               out_signal_id, out_usable_count);
        fail_count++;
      end else begin
        exp_n = pending_notices.pop_front();
        if (out_result_kind !== exp_n.result_kind) begin
          $error("result_kind exp %0d got %0d", exp_n.result_kind, out_result_kind);
          fail_count++;
        end
        if (out_signal_id !== exp_n.signal_id) begin
          $error("signal_id exp %0d got %0d", exp_n.signal_id, out_signal_id);
          fail_count++;
        end
        if (out_crossed_threshold !== exp_n.crossed_threshold) begin
          $error("crossed_threshold exp %0d got %0d", exp_n.crossed_threshold,
                 out_crossed_threshold);
          fail_count++;
        end
        if (out_level_index !== exp_n.level_index) begin
          $error("level_index exp %0d got %0d", $signed(exp_n.level_index), out_level_index);
          fail_count++;
        end
        if (out_entry_count !== exp_n.entry_count) begin
          $error("entry_count exp %0d got %0d", exp_n.entry_count, out_entry_count);
          fail_count++;
        end
        if (out_usable_count !== exp_n.usable_count) begin
          $error("usable_count exp %0d got %0d", exp_n.usable_count, out_usable_count);
          fail_count++;
        end
        if (out_status !== exp_n.status) begin
          $error("status exp %0d got %0d", exp_n.status, out_status);
          fail_count++;
        end
        if (out_last !== exp_n.last) begin
          $error("last exp %0d got %0d", exp_n.last, out_last);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [PW-1:0] clamp_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [PW-1:0] clamp_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PW] ? PAGE_MAX : sum[PW-1:0];
  endfunction

  task automatic push_crossing(input int idx, input logic [PW-1:0] usable);
    notice_t n;
    n.result_kind = 1'b0;
    n.signal_id = shadow_id[idx];
    n.crossed_threshold = shadow_thr[idx];
    n.level_index = '0;
    n.entry_count = '0;
    n.usable_count = usable;
    n.status = 1'b0;
    n.last = 1'b0;
    crossings_seen++;
    pending_notices.push_back(n);
  endtask

  // Walk down from the level past every threshold now below usage (entry 0 included),
  // then up past every threshold now at or above it; signal each one passed.
  task automatic walk_levels(input logic [PW-1:0] usable);
    int i;
    if (shadow_count == 0) return;
    i = shadow_level;
    if (i >= shadow_count) i = shadow_count - 1;
    while (i >= 0 && shadow_thr[i] < usable) begin
      push_crossing(i, usable);
      i--;
    end
    i++;
    while (i < shadow_count && shadow_thr[i] >= usable) begin
      push_crossing(i, usable);
      i++;
    end
    shadow_level = i - 1;
  endtask

  task automatic predict_request(input mem_request_t r);
    logic [PW-1:0] free_part;
    logic [PW-1:0] file_part;
    logic [PW-1:0] usable;
    logic [63:0] thr_wide;
    logic [PW-1:0] thr;
    logic st;
    int pos;
    int j;
    int lvl;
    notice_t n;
    free_part = clamp_sub(r.free_cnt, r.reserve_pages);
    file_part = clamp_sub(r.file_pages, r.swapcache_pages);
    if (swap_on) free_part = clamp_add(free_part, r.swap_free_pages);
    usable = clamp_sub(clamp_add(free_part, file_part), ws_pages);
    st = 1'b0;
    if (r.req_type == REQ_SAMPLE || r.req_type == REQ_REG) walk_levels(usable);
    if (r.req_type == REQ_REG) begin
      if (shadow_count >= NTHR) begin
        st = 1'b1;
        full_errors++;
      end else begin
        thr_wide = (64'(r.threshold_percent) * 64'(total_cfg)) / PERCENT_BASE;
        thr = (thr_wide > 64'(PAGE_MAX)) ? PAGE_MAX : thr_wide[PW-1:0];
        pos = 0;
        while (pos < shadow_count && shadow_thr[pos] >= thr) pos++;
        for (j = shadow_count; j > pos; j--) begin
          shadow_thr[j] = shadow_thr[j-1];
          shadow_id[j] = shadow_id[j-1];
        end
        shadow_thr[pos] = thr;
        shadow_id[pos] = r.event_id;
        shadow_count++;
        lvl = -1;
        for (j = 0; j < shadow_count; j++) if (shadow_thr[j] >= usable) lvl++;
        shadow_level = lvl;
      end
    end else if (r.req_type == REQ_CLEAR) begin
      shadow_count = 0;
      shadow_level = -1;
    end
    n.result_kind = 1'b1;
    n.signal_id = '0;
    n.crossed_threshold = '0;
    n.level_index = shadow_level[LVL_OUT_W-1:0];
    n.entry_count = shadow_count[CNT_OUT_W-1:0];
    n.usable_count = usable;
    n.status = st;
    n.last = 1'b1;
    pending_notices.push_back(n);
  endtask

  // Offer one request, hold it until accepted, then predict it. Called at a clock edge.
  task automatic send_request(input mem_request_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_free_pages <= r.free_cnt;
    in_reserve_pages <= r.reserve_pages;
    in_file_pages <= r.file_pages;
    in_swapcache_pages <= r.swapcache_pages;
    in_swap_free_pages <= r.swap_free_pages;
    in_threshold_percent <= r.threshold_percent;
    in_event_id <= r.event_id;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    predict_request(r);
  endtask

  // Drop valid and wait until every pending notice has arrived, plus a settle margin.
  task automatic drain_notices();
    in_valid <= 1'b0;
    while (pending_notices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain_notices();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WORKING_SET: ws_pages = val;
      CFG_TOTAL_PAGES: total_cfg = val;
      CFG_SWAP_ENABLE: swap_on = val[0];
      default: ;
    endcase
  endtask

  function automatic mem_request_t make_req(input logic [REQ_W-1:0] t,
      input logic [PW-1:0] fr, input logic [PW-1:0] rs, input logic [PW-1:0] fl,
      input logic [PW-1:0] sc, input logic [PW-1:0] sw, input logic [PCT_W-1:0] pct,
      input logic [ID_W-1:0] id);
    mem_request_t r;
    r.req_type = t;
    r.free_cnt = fr;
    r.reserve_pages = rs;
    r.file_pages = fl;
    r.swapcache_pages = sc;
    r.swap_free_pages = sw;
    r.threshold_percent = pct;
    r.event_id = id;
    return r;
  endfunction

  // Mostly samples and registers scaled to the configured total so usage sweeps across
  // the thresholds; some clears, some unused codes, some fully random page counts.
  function automatic mem_request_t random_req();
    mem_request_t r;
    int pick;
    logic [PW-1:0] scale;
    scale = (total_cfg < 1000) ? 32'd1000 : total_cfg;
    pick = $urandom_range(99);
    if (pick < 55) r.req_type = REQ_SAMPLE;
    else if (pick < 82) r.req_type = REQ_REG;
    else if (pick < 92) r.req_type = REQ_CLEAR;
    else r.req_type = REQ_UNUSED;
    if ($urandom_range(9) == 0) begin
      r.free_cnt = $urandom;
      r.reserve_pages = $urandom;
      r.file_pages = $urandom;
      r.swapcache_pages = $urandom;
      r.swap_free_pages = $urandom;
    end else begin
      r.free_cnt = $urandom_range(0, scale);
      r.reserve_pages = $urandom_range(0, scale / 8);
      r.file_pages = $urandom_range(0, scale / 2);
      r.swapcache_pages = $urandom_range(0, scale / 8);
      r.swap_free_pages = $urandom_range(0, scale / 4);
    end
    r.threshold_percent = ($urandom_range(7) == 0) ? PCT_W'($urandom_range(0, 127))
                                                   : PCT_W'($urandom_range(0, 100));
    r.event_id = ID_W'($urandom);
    return r;
  endfunction

  task automatic randomize_config();
    int pick;
    pick = $urandom_range(3);
    case (pick)
      0: write_config(CFG_TOTAL_PAGES, 32'd5000);
      1: write_config(CFG_TOTAL_PAGES, 32'd100000);
      2: write_config(CFG_TOTAL_PAGES, PAGE_MAX);
      default: write_config(CFG_TOTAL_PAGES, $urandom);
    endcase
    write_config(CFG_WORKING_SET, $urandom_range(0, total_cfg / 10));
    write_config(CFG_SWAP_ENABLE, $urandom_range(1));
  endtask

  // Field extremes, every request code, clamps and saturations, config extremes.
  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(make_req(REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SAMPLE, '1, '1, '1, '1, '1, 7'd127, '1));
    send_request(make_req(REQ_UNUSED, 32'd99999, 0, 0, 0, 0, 7'd50, 10'd5));
    send_request(make_req(REQ_REG, 32'd50000, 0, 0, 0, 0, 7'd50, 10'd1));
    write_config(CFG_WORKING_SET, '0);
    write_config(CFG_TOTAL_PAGES, 32'd1000);
    write_config(CFG_SWAP_ENABLE, 32'd1);
    send_request(make_req(REQ_REG, 32'd500, 0, 0, 0, 0, 7'd100, 10'h3ff));
    send_request(make_req(REQ_REG, 32'd500, 0, 0, 0, 0, 7'd127, 10'd2));
    send_request(make_req(REQ_REG, 32'd500, 0, 0, 0, 0, 7'd50, 10'd3));
    send_request(make_req(REQ_REG, 32'd500, 0, 0, 0, 0, 7'd50, 10'd4));
    send_request(make_req(REQ_SAMPLE, 32'd2000, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SAMPLE, 32'd100, 32'd300, 32'd50, 32'd900, 32'd700, 0, 0));
    send_request(make_req(REQ_SAMPLE, '1, 0, '1, 0, '1, 0, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SAMPLE, 32'd600, 0, 0, 0, 0, 0, 0));
    write_config(CFG_TOTAL_PAGES, PAGE_MAX);
    send_request(make_req(REQ_REG, 32'd10, 0, 0, 0, 0, 7'd127, 10'd9));
    send_request(make_req(REQ_REG, 32'd10, 0, 0, 0, 0, 7'd100, 10'd10));
    send_request(make_req(REQ_SAMPLE, '1, 0, '1, 0, '1, 0, 0));
    write_config(CFG_WORKING_SET, PAGE_MAX);
    write_config(CFG_SWAP_ENABLE, 32'd0);
    send_request(make_req(REQ_SAMPLE, '1, 0, '1, 0, '1, 0, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Fill the table to its limit, overflow it once, then sweep usage across it.
  task automatic test_table_full();
    int k;
    write_config(CFG_WORKING_SET, '0);
    write_config(CFG_TOTAL_PAGES, 32'd10000);
    for (k = 0; k <= NTHR; k++)
      send_request(make_req(REQ_REG, $urandom_range(0, 10000), 0, 0, 0, 0,
                            PCT_W'($urandom_range(0, 100)), ID_W'($urandom)));
    send_request(make_req(REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SAMPLE, 32'd20000, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SAMPLE, 32'd5000, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
    int k;
    randomize_config();
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < n; k++) begin
      send_request(random_req());
      if (k == n / 2) randomize_config();
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so the
  // block backs up and stalls its input.
  task automatic test_backpressure();
    int k;
    sender_idle_pct = 0;
    recv_stall_pct = 10;
    hold_start = 400;
    for (k = 0; k < 12; k++) send_request(random_req());
  endtask

  // Pause the sender until every pending notice has come, then resume.
  task automatic test_sender_pause();
    int k;
    sender_idle_pct = 24;
    recv_stall_pct = 24;
    for (k = 0; k < 5; k++) send_request(random_req());
    in_valid <= 1'b0;
    while (pending_notices.size() != 0) @(posedge clk);
    for (k = 0; k < 5; k++) send_request(random_req());
  endtask

  initial begin
    shadow_count = 0;
    shadow_level = -1;
    ws_pages = WS_RESET_PAGES;
    total_cfg = '0;
    swap_on = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random_phase(25, 0, 0);
    test_random_phase(25, 65, 0);
    test_random_phase(25, 0, 65);
    test_random_phase(25, 24, 24);
    test_backpressure();
    test_sender_pause();

    in_valid <= 1'b0;
    while (pending_notices.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Covered %0d requests: %0d results, %0d threshold crossings, %0d full-table",
             requests_sent, notices_seen, crossings_seen, full_errors);
    $display("rejections, over four idle/stall mixes, a long output hold-off and config extremes");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
